FILE: design/winch_position_state_controller_defines.svh
// Assertion macros shared by the winch position controller.
`ifndef WINCH_POSITION_STATE_CONTROLLER_DEFINES_SVH
`define WINCH_POSITION_STATE_CONTROLLER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define WPSC_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("wpsc: invariant violated");

// A condition that must hold whenever the antecedent holds.
`define WPSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpsc: implication violated");

`endif

FILE: design/wpsc_pkg.sv
// Types, field widths and codes for the winch position controller.
`default_nettype none

package wpsc_pkg;

    localparam int unsigned ActionW  = 3;
    localparam int unsigned PosW     = 16;
    localparam int unsigned CurW     = 16;
    localparam int unsigned TgtW     = 15;
    localparam int unsigned StatusW  = 3;
    localparam int unsigned DriveW   = 2;
    localparam int unsigned SpeedW   = 17;
    localparam int unsigned DutyW    = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned SpdW     = 16;
    localparam int unsigned DistW    = 15;
    localparam int unsigned DockW    = 4;
    localparam int unsigned DockRemW = DockW + 1;
    localparam int unsigned SpdValW  = 18;
    localparam int unsigned ErrW     = PosW + 1;
    localparam int unsigned ErrMagW  = 7;
    localparam int unsigned ProdW    = ErrMagW + SpdW;
    localparam int unsigned RecipW   = 24;
    localparam int unsigned QuotW    = ProdW + RecipW;

    // Number of open-loop steps in the docking ramp.
    localparam int unsigned DockSteps = 10;

    // Multiply by this and shift right to divide a product by 100.
    localparam logic [RecipW-1:0] Div100Mul   = 24'd10737419;
    localparam int unsigned       Div100Shift = 30;

    localparam logic [ActionW-1:0] ACT_TICK       = 3'd0;
    localparam logic [ActionW-1:0] ACT_ENABLE     = 3'd1;
    localparam logic [ActionW-1:0] ACT_DISABLE    = 3'd2;
    localparam logic [ActionW-1:0] ACT_MANUAL_ON  = 3'd3;
    localparam logic [ActionW-1:0] ACT_MANUAL_OFF = 3'd4;
    localparam logic [ActionW-1:0] ACT_SET_TARGET = 3'd5;

    localparam logic [DriveW-1:0] DRV_OFF   = 2'd0;
    localparam logic [DriveW-1:0] DRV_SPEED = 2'd1;
    localparam logic [DriveW-1:0] DRV_DUTY  = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_HOME_THR     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RETURN_SPEED = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SEARCH_SPEED = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GROUND_SPEED = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_GROUND_DIST  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_ACCEL_STEP   = 3'd6;

    localparam logic [CurW-1:0]  RstHomeThr     = 16'd1000;
    localparam logic [SpdW-1:0]  RstReturnSpeed = 16'd1600;
    localparam logic [SpdW-1:0]  RstSearchSpeed = 16'd400;
    localparam logic [SpdW-1:0]  RstGroundSpeed = 16'd400;
    localparam logic [DistW-1:0] RstGroundDist  = 15'd500;
    localparam logic [SpdW-1:0]  RstMaxSpeed    = 16'd3200;
    localparam logic [SpdW-1:0]  RstAccelStep   = 16'd16;

    localparam logic signed [PosW-1:0] PosAtHome   = 16'sd10;
    localparam logic signed [PosW-1:0] PosLeaveDock = 16'sd20;
    localparam logic signed [PosW-1:0] PosFar      = 16'sd800;
    localparam logic [ErrW-1:0]        ErrStop     = 17'd10;
    localparam logic [ErrW-1:0]        ErrProp     = 17'd100;

    localparam logic signed [SpdValW-1:0] SpeedSatHi = 18'sd65535;
    localparam logic signed [SpdValW-1:0] SpeedSatLo = -18'sd65535;

    localparam logic signed [DutyW-1:0] DUTY_FINAL  = -8'sd20;
    localparam logic signed [DutyW-1:0] DUTY_THIRD  = -8'sd30;
    localparam logic signed [DutyW-1:0] DUTY_FOURTH = -8'sd40;
    localparam logic signed [DutyW-1:0] DUTY_FULL   = -8'sd80;

    typedef enum logic [2:0] {
        SP_KEEP,
        SP_ZERO,
        SP_SET,
        SP_PROP,
        SP_ACCEL
    } t_speed_op;

    // Open-loop duty for a docking step that lies before the end of the ramp.
    function automatic logic signed [DutyW-1:0] dock_duty(input logic [DockW-1:0] step);
        logic [DockRemW-1:0] remain;
        logic signed [DutyW-1:0] duty;
        remain = DockRemW'(DockSteps) - {1'b0, step};
        if (remain <= DockRemW'(2)) begin
            duty = DUTY_FINAL;
        end else if (remain == DockRemW'(3)) begin
            duty = DUTY_THIRD;
        end else if (remain == DockRemW'(4)) begin
            duty = DUTY_FOURTH;
        end else begin
            duty = DUTY_FULL;
        end
        return duty;
    endfunction

endpackage

`default_nettype wire

FILE: design/wpsc_if.sv
// Handshake channels for the winch position controller input and result transactions.
`default_nettype none

interface wpsc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [wpsc_pkg::ActionW-1:0]         action;
    logic signed [wpsc_pkg::PosW-1:0]     position_mm;
    logic [wpsc_pkg::CurW-1:0]            current_ma;
    logic                                 motor_stopped;
    logic [wpsc_pkg::TgtW-1:0]            target_mm;

    modport source (
        output valid, action, position_mm, current_ma, motor_stopped, target_mm,
        input  ready
    );
    modport sink (
        input  valid, action, position_mm, current_ma, motor_stopped, target_mm,
        output ready
    );
endinterface

interface wpsc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [wpsc_pkg::StatusW-1:0]         status;
    logic [wpsc_pkg::DriveW-1:0]          drive_mode;
    logic signed [wpsc_pkg::SpeedW-1:0]   speed_command;
    logic signed [wpsc_pkg::DutyW-1:0]    duty_command;
    logic                                 save_home;
    logic                                 pid_reset;

    modport source (
        output valid, status, drive_mode, speed_command, duty_command, save_home, pid_reset,
        input  ready
    );
    modport sink (
        input  valid, status, drive_mode, speed_command, duty_command, save_home, pid_reset,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/winch_position_state_controller.sv
// Winch position sequencer: mode control, docking ramp and speed command generation.
//
//  Port        Dir  Carries
//  i_item      in   action, position_mm, current_ma, motor_stopped, target_mm
//  o_result    out  status, drive_mode, speed_command, duty_command, save_home, pid_reset
//  i_cfg_*     in   register index and write data, one write per cycle
//
// One transaction is accepted per cycle unless o_result stalls; each passes the input, mid and output registers.
// The first stage updates the mode state and forms the proportional product, the second
// divides it by 100 with a reciprocal multiply and updates the speed value.
// Every stage moves forward when its successor has room, so bubbles are absorbed.
// The synchronous reset loads the register reset values and empties the pipeline.
`default_nettype none

`include "winch_position_state_controller_defines.svh"

module winch_position_state_controller (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    wpsc_in_if.sink                               i_item,
    wpsc_out_if.source                            o_result,
    input  wire logic                             i_cfg_we,
    input  wire logic [wpsc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [wpsc_pkg::CfgDataW-1:0]    i_cfg_wdata
);
    import wpsc_pkg::*;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_HOME    = 3'd1,
        ST_GOHOME  = 3'd2,
        ST_DOCK    = 3'd3,
        ST_LOWER   = 3'd4,
        ST_LOWERED = 3'd5,
        ST_MANUAL  = 3'd6
    } t_mode;

    typedef struct packed {
        t_speed_op                 op;
        logic signed [SpeedW-1:0]  set_val;
        logic [ProdW-1:0]          prod;
        logic                      neg;
        logic [StatusW-1:0]        status;
        logic [DriveW-1:0]         drive;
        logic signed [DutyW-1:0]   duty;
        logic                      save_home;
        logic                      pid_reset;
    } t_mid;

    logic [CurW-1:0]  r_home_thr;
    logic [SpdW-1:0]  r_return_speed;
    logic [SpdW-1:0]  r_search_speed;
    logic [SpdW-1:0]  r_ground_speed;
    logic [DistW-1:0] r_ground_dist;
    logic [SpdW-1:0]  r_max_speed;
    logic [SpdW-1:0]  r_accel_step;

    logic                    r_in_valid;
    logic [ActionW-1:0]      r_in_action;
    logic signed [PosW-1:0]  r_in_pos;
    logic [CurW-1:0]         r_in_cur;
    logic                    r_in_stopped;
    logic [TgtW-1:0]         r_in_target;

    t_mode                   r_mode;
    logic                    r_enabled;
    logic [DockW-1:0]        r_dock;
    logic signed [PosW-1:0]  r_target;
    logic                    r_loop;
    logic signed [SpdValW-1:0] r_speed;

    logic r_mid_valid;
    t_mid r_mid;

    logic                      r_out_valid;
    logic [StatusW-1:0]        r_out_status;
    logic [DriveW-1:0]         r_out_drive;
    logic signed [SpeedW-1:0]  r_out_speed;
    logic signed [DutyW-1:0]   r_out_duty;
    logic                      r_out_save;
    logic                      r_out_pid;

    t_mode                   n_mode;
    logic                    n_enabled;
    logic [DockW-1:0]        n_dock;
    logic signed [PosW-1:0]  n_target;
    logic                    n_loop;
    t_mid                    n_mid;
    logic signed [SpdValW-1:0] n_speed;
    logic signed [SpeedW-1:0]  n_out_speed;

    logic out_load;
    logic mid_load;
    logic in_load;

    logic [ErrW-1:0]    err;
    logic [ErrW-1:0]    err_mag;
    logic [ProdW-1:0]   prod;
    logic [QuotW-1:0]   quot_full;
    logic [SpdW-1:0]    quot;

    assign out_load = !r_out_valid || o_result.ready;
    assign mid_load = !r_mid_valid || out_load;
    assign in_load  = !r_in_valid || mid_load;
    assign i_item.ready = in_load;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_thr     <= RstHomeThr;
            r_return_speed <= RstReturnSpeed;
            r_search_speed <= RstSearchSpeed;
            r_ground_speed <= RstGroundSpeed;
            r_ground_dist  <= RstGroundDist;
            r_max_speed    <= RstMaxSpeed;
            r_accel_step   <= RstAccelStep;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOME_THR:     r_home_thr     <= i_cfg_wdata;
                CFG_RETURN_SPEED: r_return_speed <= i_cfg_wdata;
                CFG_SEARCH_SPEED: r_search_speed <= i_cfg_wdata;
                CFG_GROUND_SPEED: r_ground_speed <= i_cfg_wdata;
                CFG_GROUND_DIST:  r_ground_dist  <= i_cfg_wdata[DistW-1:0];
                CFG_MAX_SPEED:    r_max_speed    <= i_cfg_wdata;
                CFG_ACCEL_STEP:   r_accel_step   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_item.valid;
        end
        if (in_load && i_item.valid) begin
            r_in_action  <= i_item.action;
            r_in_pos     <= i_item.position_mm;
            r_in_cur     <= i_item.current_ma;
            r_in_stopped <= i_item.motor_stopped;
            r_in_target  <= i_item.target_mm;
        end
    end

    assign err     = {r_target[PosW-1], r_target} - {r_in_pos[PosW-1], r_in_pos};
    assign err_mag = err[ErrW-1] ? (ErrW'(0) - err) : err;
    assign prod    = ProdW'(err_mag[ErrMagW-1:0]) * ProdW'(r_ground_speed);

    // Mode sequencing for the transaction in the input register.
    always_comb begin
        n_mode    = r_mode;
        n_enabled = r_enabled;
        n_dock    = r_dock;
        n_target  = r_target;
        n_loop    = r_loop;
        n_mid.op        = SP_KEEP;
        n_mid.set_val   = '0;
        n_mid.duty      = '0;
        n_mid.save_home = 1'b0;
        n_mid.pid_reset = 1'b0;
        case (r_in_action)
            ACT_TICK: begin
                if (r_enabled) begin
                    case (r_mode)
                        ST_DOCK: begin
                            if (r_dock < DockW'(DockSteps)) begin
                                if (r_dock == '0) begin
                                    n_loop = 1'b0;
                                end
                                n_mid.duty = dock_duty(r_dock);
                            end else begin
                                n_loop = 1'b1;
                                n_mid.pid_reset = 1'b1;
                                n_mode = ST_HOME;
                            end
                            if (r_dock != '1) begin
                                n_dock = r_dock + DockW'(1);
                            end
                        end
                        ST_GOHOME: begin
                            if (r_in_cur > r_home_thr) begin
                                n_mid.op = SP_ZERO;
                                n_dock = '0;
                                n_mode = ST_DOCK;
                                n_mid.save_home = 1'b1;
                                n_target = '0;
                            end else if (r_in_pos > PosFar) begin
                                n_mid.op = SP_SET;
                                n_mid.set_val = SpeedW'(0) - {1'b0, r_return_speed};
                            end else begin
                                n_mid.op = SP_SET;
                                n_mid.set_val = SpeedW'(0) - {1'b0, r_search_speed};
                            end
                        end
                        ST_HOME: begin
                            if (r_in_pos > PosLeaveDock) begin
                                n_mode = ST_GOHOME;
                            end
                            n_mid.op = SP_ZERO;
                        end
                        ST_LOWER: begin
                            if (err_mag <= ErrStop) begin
                                n_mid.op = SP_ZERO;
                                if (r_in_stopped) begin
                                    n_mode = ST_LOWERED;
                                end
                            end else if (err_mag <= ErrProp) begin
                                n_mid.op = SP_PROP;
                            end else if ($signed(err) <= $signed({2'b00, r_ground_dist})) begin
                                n_mid.op = SP_SET;
                                n_mid.set_val = {1'b0, r_ground_speed};
                            end else begin
                                n_mid.op = SP_ACCEL;
                            end
                        end
                        ST_LOWERED: begin
                            if (err_mag > ErrStop) begin
                                n_mode = ST_LOWER;
                            end
                        end
                        ST_MANUAL: ;
                        default: begin
                            n_mid.op = SP_ZERO;
                        end
                    endcase
                end
            end
            ACT_ENABLE: begin
                if (!r_enabled) begin
                    n_enabled = 1'b1;
                    n_loop = 1'b1;
                    n_target = r_in_pos;
                    n_mode = (r_in_pos < PosAtHome) ? ST_HOME : ST_LOWERED;
                end
            end
            ACT_DISABLE: begin
                if (r_enabled) begin
                    n_mid.op = SP_ZERO;
                    n_enabled = 1'b0;
                    n_mode = ST_UNKNOWN;
                    n_target = '0;
                end
            end
            ACT_MANUAL_ON: begin
                if (r_mode != ST_MANUAL) begin
                    if (r_mode == ST_DOCK) begin
                        n_mid.pid_reset = 1'b1;
                        n_loop = 1'b1;
                    end
                    n_mode = ST_MANUAL;
                    n_mid.op = SP_ZERO;
                    n_target = '0;
                end
            end
            ACT_MANUAL_OFF: begin
                if (r_mode == ST_MANUAL) begin
                    n_mid.op = SP_ZERO;
                    n_target = r_in_pos;
                    n_mode = (r_in_pos < PosAtHome) ? ST_HOME : ST_LOWERED;
                end
            end
            ACT_SET_TARGET: begin
                n_target = {1'b0, r_in_target};
            end
            default: ;
        endcase
        n_mid.prod   = prod;
        n_mid.neg    = err[ErrW-1];
        n_mid.status = n_mode;
        if (!n_enabled) begin
            n_mid.drive = DRV_OFF;
        end else if (n_loop) begin
            n_mid.drive = DRV_SPEED;
        end else begin
            n_mid.drive = DRV_DUTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_UNKNOWN;
            r_enabled   <= 1'b0;
            r_dock      <= '0;
            r_target    <= '0;
            r_loop      <= 1'b1;
            r_mid_valid <= 1'b0;
        end else if (mid_load) begin
            r_mid_valid <= r_in_valid;
            if (r_in_valid) begin
                r_mode    <= n_mode;
                r_enabled <= n_enabled;
                r_dock    <= n_dock;
                r_target  <= n_target;
                r_loop    <= n_loop;
            end
        end
        if (mid_load && r_in_valid) begin
            r_mid <= n_mid;
        end
    end

    assign quot_full = QuotW'(r_mid.prod) * QuotW'(Div100Mul);
    assign quot      = SpdW'(quot_full >> Div100Shift);

    // Speed value update and saturation of the command, which is zero while the drive is off.
    always_comb begin
        case (r_mid.op)
            SP_KEEP:  n_speed = r_speed;
            SP_ZERO:  n_speed = '0;
            SP_SET:   n_speed = SpdValW'(r_mid.set_val);
            SP_PROP: begin
                if (r_mid.neg) begin
                    n_speed = SpdValW'(0) - {2'b00, quot};
                end else begin
                    n_speed = {2'b00, quot};
                end
            end
            SP_ACCEL: begin
                if ($signed({r_speed[SpdValW-1], r_speed}) < $signed({3'b000, r_max_speed})) begin
                    n_speed = r_speed + {2'b00, r_accel_step};
                end else begin
                    n_speed = {2'b00, r_max_speed};
                end
            end
            default:  n_speed = r_speed;
        endcase
        if (r_mid.drive == DRV_OFF) begin
            n_out_speed = '0;
        end else if (n_speed > SpeedSatHi) begin
            n_out_speed = SpeedW'(SpeedSatHi);
        end else if (n_speed < SpeedSatLo) begin
            n_out_speed = SpeedW'(SpeedSatLo);
        end else begin
            n_out_speed = SpeedW'(n_speed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_mid_valid;
            if (r_mid_valid) begin
                r_speed <= n_speed;
            end
        end
        if (out_load && r_mid_valid) begin
            r_out_status <= r_mid.status;
            r_out_drive  <= r_mid.drive;
            r_out_speed  <= n_out_speed;
            r_out_duty   <= r_mid.duty;
            r_out_save   <= r_mid.save_home;
            r_out_pid    <= r_mid.pid_reset;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.status        = r_out_status;
    assign o_result.drive_mode    = r_out_drive;
    assign o_result.speed_command = r_out_speed;
    assign o_result.duty_command  = r_out_duty;
    assign o_result.save_home     = r_out_save;
    assign o_result.pid_reset     = r_out_pid;

    `WPSC_ASSERT_IMPLIES(a_unknown_disabled, i_clk, i_rst_n, r_mode == ST_UNKNOWN, !r_enabled)
    `WPSC_ASSERT_IMPLIES(a_off_no_speed, i_clk, i_rst_n, r_out_valid && (r_out_drive == DRV_OFF), r_out_speed == '0)
    `WPSC_ASSERT_IMPLIES(a_duty_open_loop, i_clk, i_rst_n, r_out_valid && (r_out_duty != '0), r_out_drive == DRV_DUTY)
    `WPSC_ASSERT_HOLDS(a_pulses_apart, i_clk, i_rst_n, !(r_out_valid && r_out_save && r_out_pid))

endmodule

`default_nettype wire
